### sv/tcfe_pkg.sv
package tcfe_pkg;

    localparam int ADDR_W = 11;
    localparam int DATA_W = 8;
    localparam int OPC_W  = 5;
    localparam int IR_W   = 16;

    // Span of an 11-bit address; stores are indexed modulo their depth.
    localparam int ADDR_SPAN = 2048;

    localparam int MEM_DEPTH_DEF = 2048;
    localparam int IO_DEPTH_DEF  = 32;

    localparam logic [1:0] REQ_LOAD     = 2'd0;
    localparam logic [1:0] REQ_STEP     = 2'd1;
    localparam logic [1:0] REQ_READ_MEM = 2'd2;
    localparam logic [1:0] REQ_READ_IO  = 2'd3;

    localparam logic [OPC_W-1:0] OP_WM  = 5'h01;
    localparam logic [OPC_W-1:0] OP_RM  = 5'h02;
    localparam logic [OPC_W-1:0] OP_BR  = 5'h03;
    localparam logic [OPC_W-1:0] OP_RIO = 5'h04;
    localparam logic [OPC_W-1:0] OP_WIO = 5'h05;
    localparam logic [OPC_W-1:0] OP_WB  = 5'h06;
    localparam logic [OPC_W-1:0] OP_WIB = 5'h07;
    localparam logic [OPC_W-1:0] OP_EOP = 5'h1F;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_FETCH_LO,
        S_EXEC,
        S_FINISH
    } state_t;

    // One access to a store: address is the raw 11-bit value, reduced inside.
    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } store_req_t;

endpackage

### sv/tcfe_main_mem.sv
module tcfe_main_mem #(
    parameter int DEPTH = tcfe_pkg::MEM_DEPTH_DEF
) (
    input  logic                        clk,
    input  tcfe_pkg::store_req_t        req,
    output logic [tcfe_pkg::DATA_W-1:0] rdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int STEPS = $clog2((tcfe_pkg::ADDR_SPAN + DEPTH - 1) / DEPTH);

    logic [tcfe_pkg::DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]               idx;

    // Reduce modulo DEPTH by conditional subtraction of DEPTH scaled by powers of two.
    function automatic logic [AW-1:0] mem_index(input logic [tcfe_pkg::ADDR_W-1:0] a);
        logic [tcfe_pkg::ADDR_W:0] r;
        r = {1'b0, a};
        for (int k = STEPS - 1; k >= 0; k--) begin
            if (32'(r) >= (DEPTH << k)) begin
                r = r - (tcfe_pkg::ADDR_W + 1)'(DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    assign idx = mem_index(req.addr);

    always_ff @(posedge clk)
    begin
        if (req.we) begin
            mem[idx] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[idx];
        end
    end

endmodule

### sv/tcfe_io_mem.sv
module tcfe_io_mem #(
    parameter int DEPTH = tcfe_pkg::IO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcfe_pkg::store_req_t        req,
    output logic [tcfe_pkg::DATA_W-1:0] rdata,
    output logic                        busy
);

    localparam int AW    = $clog2(DEPTH);
    localparam int STEPS = $clog2((tcfe_pkg::ADDR_SPAN + DEPTH - 1) / DEPTH);

    logic [tcfe_pkg::DATA_W-1:0] mem [DEPTH];
    logic [AW:0]                 clr_cnt_reg;
    logic [AW:0]                 clr_cnt_next;
    logic [AW-1:0]               idx;
    logic [AW-1:0]               waddr;
    logic [tcfe_pkg::DATA_W-1:0] wdata;
    logic                        we;

    function automatic logic [AW-1:0] io_index(input logic [tcfe_pkg::ADDR_W-1:0] a);
        logic [tcfe_pkg::ADDR_W:0] r;
        r = {1'b0, a};
        for (int k = STEPS - 1; k >= 0; k--) begin
            if (32'(r) >= (DEPTH << k)) begin
                r = r - (tcfe_pkg::ADDR_W + 1)'(DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    assign idx  = io_index(req.addr);
    assign busy = (clr_cnt_reg != (AW + 1)'(DEPTH));

    // Sweep zeros through every entry after reset.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (busy) begin
            clr_cnt_next = clr_cnt_reg + (AW + 1)'(1);
            waddr        = clr_cnt_reg[AW-1:0];
            wdata        = '0;
            we           = 1'b1;
        end else begin
            waddr = idx;
            wdata = req.wdata;
            we    = req.we;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (req.re) begin
            rdata <= mem[idx];
        end
    end

endmodule

### sv/toy_cpu_fetch_execute_top.sv
// Small fetch-execute control unit with a byte-wide main store and an I/O store.
// One item is handled at a time; in_ready is high only in the idle state. A load
// or read request is latched on acceptance and passes through the access and
// finish states; an executed instruction through access, low fetch, execute and
// finish: the single-port main store is used once for the high instruction byte,
// once for the low byte and, for a memory opcode, once for the data access, and
// finish publishes the result. A step after halt takes access and finish only. The
// result sits in an output register, so the next item is taken while it waits; a
// finished item stalls only while that register is full. After reset the I/O
// store is cleared, one entry per cycle, while in_ready stays low.
module toy_cpu_fetch_execute_top #(
    parameter int MEM_DEPTH = tcfe_pkg::MEM_DEPTH_DEF,
    parameter int IO_DEPTH  = tcfe_pkg::IO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [tcfe_pkg::ADDR_W-1:0] address,
    input  logic [tcfe_pkg::DATA_W-1:0] data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tcfe_pkg::DATA_W-1:0] read_data,
    output logic [tcfe_pkg::ADDR_W-1:0] pc,
    output logic [tcfe_pkg::OPC_W-1:0]  opcode,
    output logic [tcfe_pkg::ADDR_W-1:0] operand,
    output logic [tcfe_pkg::DATA_W-1:0] mbr,
    output logic [tcfe_pkg::DATA_W-1:0] iobr,
    output logic                        halted
);

    tcfe_pkg::state_t            state_reg,  state_next;
    logic [1:0]                  req_reg,    req_next;
    logic [tcfe_pkg::ADDR_W-1:0] addr_reg,   addr_next;
    logic [tcfe_pkg::DATA_W-1:0] data_reg,   data_next;
    logic [tcfe_pkg::ADDR_W-1:0] pc_reg,     pc_next;
    logic [tcfe_pkg::DATA_W-1:0] mbr_reg,    mbr_next;
    logic [tcfe_pkg::DATA_W-1:0] iobr_reg,   iobr_next;
    logic                        halted_reg, halted_next;
    logic                        exec_reg,   exec_next;
    logic [tcfe_pkg::DATA_W-1:0] ir_hi_reg,  ir_hi_next;
    logic [tcfe_pkg::IR_W-1:0]   ir_reg,     ir_next;

    logic                        out_valid_reg,     out_valid_next;
    logic [tcfe_pkg::DATA_W-1:0] out_read_data_reg, out_read_data_next;
    logic [tcfe_pkg::ADDR_W-1:0] out_pc_reg,        out_pc_next;
    logic [tcfe_pkg::OPC_W-1:0]  out_opcode_reg,    out_opcode_next;
    logic [tcfe_pkg::ADDR_W-1:0] out_operand_reg,   out_operand_next;
    logic [tcfe_pkg::DATA_W-1:0] out_mbr_reg,       out_mbr_next;
    logic [tcfe_pkg::DATA_W-1:0] out_iobr_reg,      out_iobr_next;
    logic                        out_halted_reg,    out_halted_next;

    tcfe_pkg::store_req_t        mem_req;
    tcfe_pkg::store_req_t        io_req;
    logic [tcfe_pkg::DATA_W-1:0] mem_rdata;
    logic [tcfe_pkg::DATA_W-1:0] io_rdata;
    logic                        io_busy;

    logic [tcfe_pkg::IR_W-1:0]   ir_word;
    logic [tcfe_pkg::OPC_W-1:0]  exec_opc;
    logic [tcfe_pkg::ADDR_W-1:0] exec_opd;
    logic [tcfe_pkg::OPC_W-1:0]  fin_opc;

    tcfe_main_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_main_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    tcfe_io_mem #(
        .DEPTH (IO_DEPTH)
    ) u_io_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (io_req),
        .rdata (io_rdata),
        .busy  (io_busy)
    );

    assign in_ready = (state_reg == tcfe_pkg::S_IDLE) && !io_busy;

    assign ir_word  = {ir_hi_reg, mem_rdata};
    assign exec_opc = ir_word[15:11];
    assign exec_opd = ir_word[10:0];
    assign fin_opc  = ir_reg[15:11];

    always_comb
    begin
        state_next         = state_reg;
        req_next           = req_reg;
        addr_next          = addr_reg;
        data_next          = data_reg;
        pc_next            = pc_reg;
        mbr_next           = mbr_reg;
        iobr_next          = iobr_reg;
        halted_next        = halted_reg;
        exec_next          = exec_reg;
        ir_hi_next         = ir_hi_reg;
        ir_next            = ir_reg;
        out_valid_next     = out_valid_reg;
        out_read_data_next = out_read_data_reg;
        out_pc_next        = out_pc_reg;
        out_opcode_next    = out_opcode_reg;
        out_operand_next   = out_operand_reg;
        out_mbr_next       = out_mbr_reg;
        out_iobr_next      = out_iobr_reg;
        out_halted_next    = out_halted_reg;
        mem_req            = '0;
        io_req             = '0;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tcfe_pkg::S_IDLE: begin
                if (in_valid && in_ready) begin
                    req_next   = req_type;
                    addr_next  = address;
                    data_next  = data;
                    state_next = tcfe_pkg::S_ACCESS;
                end
            end
            tcfe_pkg::S_ACCESS: begin
                exec_next  = 1'b0;
                state_next = tcfe_pkg::S_FINISH;
                case (req_reg)
                    tcfe_pkg::REQ_LOAD: begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = addr_reg;
                        mem_req.wdata = data_reg;
                    end
                    tcfe_pkg::REQ_READ_MEM: begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = addr_reg;
                    end
                    tcfe_pkg::REQ_READ_IO: begin
                        io_req.re   = 1'b1;
                        io_req.addr = addr_reg;
                    end
                    default: begin
                        // Step: fetch the high byte unless halted.
                        if (!halted_reg) begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = pc_reg;
                            exec_next    = 1'b1;
                            state_next   = tcfe_pkg::S_FETCH_LO;
                        end
                    end
                endcase
            end
            tcfe_pkg::S_FETCH_LO: begin
                mem_req.re   = 1'b1;
                mem_req.addr = pc_reg + tcfe_pkg::ADDR_W'(1);
                ir_hi_next   = mem_rdata;
                state_next   = tcfe_pkg::S_EXEC;
            end
            tcfe_pkg::S_EXEC: begin
                ir_next    = ir_word;
                pc_next    = pc_reg + tcfe_pkg::ADDR_W'(2);
                state_next = tcfe_pkg::S_FINISH;
                case (exec_opc)
                    tcfe_pkg::OP_WM: begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = exec_opd;
                        mem_req.wdata = mbr_reg;
                    end
                    tcfe_pkg::OP_RM: begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = exec_opd;
                    end
                    tcfe_pkg::OP_BR: begin
                        pc_next = exec_opd;
                    end
                    tcfe_pkg::OP_RIO: begin
                        io_req.re   = 1'b1;
                        io_req.addr = exec_opd;
                    end
                    tcfe_pkg::OP_WIO: begin
                        io_req.we    = 1'b1;
                        io_req.addr  = exec_opd;
                        io_req.wdata = iobr_reg;
                    end
                    tcfe_pkg::OP_WB: begin
                        mbr_next = ir_word[7:0];
                    end
                    tcfe_pkg::OP_WIB: begin
                        iobr_next = ir_word[7:0];
                    end
                    tcfe_pkg::OP_EOP: begin
                        halted_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            tcfe_pkg::S_FINISH: begin
                // Hold until the output register is free; store read data stays put.
                if (!out_valid_reg || out_ready) begin
                    if (exec_reg && (fin_opc == tcfe_pkg::OP_RM)) begin
                        mbr_next = mem_rdata;
                    end
                    if (exec_reg && (fin_opc == tcfe_pkg::OP_RIO)) begin
                        iobr_next = io_rdata;
                    end
                    if (req_reg == tcfe_pkg::REQ_READ_MEM) begin
                        out_read_data_next = mem_rdata;
                    end else if (req_reg == tcfe_pkg::REQ_READ_IO) begin
                        out_read_data_next = io_rdata;
                    end else begin
                        out_read_data_next = '0;
                    end
                    out_pc_next      = pc_reg;
                    out_opcode_next  = exec_reg ? fin_opc : '0;
                    out_operand_next = exec_reg ? ir_reg[10:0] : '0;
                    out_mbr_next     = mbr_next;
                    out_iobr_next    = iobr_next;
                    out_halted_next  = halted_reg;
                    out_valid_next   = 1'b1;
                    state_next       = tcfe_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tcfe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= tcfe_pkg::S_IDLE;
            pc_reg        <= '0;
            mbr_reg       <= '0;
            iobr_reg      <= '0;
            halted_reg    <= 1'b0;
            exec_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            mbr_reg       <= mbr_next;
            iobr_reg      <= iobr_next;
            halted_reg    <= halted_next;
            exec_reg      <= exec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg           <= req_next;
        addr_reg          <= addr_next;
        data_reg          <= data_next;
        ir_hi_reg         <= ir_hi_next;
        ir_reg            <= ir_next;
        out_read_data_reg <= out_read_data_next;
        out_pc_reg        <= out_pc_next;
        out_opcode_reg    <= out_opcode_next;
        out_operand_reg   <= out_operand_next;
        out_mbr_reg       <= out_mbr_next;
        out_iobr_reg      <= out_iobr_next;
        out_halted_reg    <= out_halted_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_read_data_reg;
    assign pc        = out_pc_reg;
    assign opcode    = out_opcode_reg;
    assign operand   = out_operand_reg;
    assign mbr       = out_mbr_reg;
    assign iobr      = out_iobr_reg;
    assign halted    = out_halted_reg;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    a_halt_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> $stable(pc_reg))
        else $error("pc moved after halt");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcfe_pkg::S_FINISH) && out_valid_reg && !out_ready
        |=> (state_reg == tcfe_pkg::S_FINISH))
        else $error("finished item overwrote pending result");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == tcfe_pkg::S_ACCESS))
        else $error("accepted item not started");

    a_no_read_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcfe_pkg::S_FINISH) |-> !mem_req.re && !io_req.re)
        else $error("store read while result data is pending");
`endif

endmodule

### bench/toy_cpu_fetch_execute_top_test.sv
`timescale 1ns / 1ps

module toy_cpu_fetch_execute_top_test;

    localparam int IO_AW      = $clog2(tcfe_pkg::IO_DEPTH_DEF);
    localparam int LIMIT      = 100000;
    localparam int TOTAL_REQS = 1100;

    // Opcodes the block does not decode
    localparam logic [tcfe_pkg::OPC_W-1:0] OP_NONE   = 5'h00;
    localparam logic [tcfe_pkg::OPC_W-1:0] OP_SPARE  = 5'h1E;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [tcfe_pkg::ADDR_W-1:0] addr;
        logic [tcfe_pkg::DATA_W-1:0] value;
        logic                        drain;
    } cpu_req_t;

    typedef struct packed {
        logic [tcfe_pkg::DATA_W-1:0] rd;
        logic [tcfe_pkg::ADDR_W-1:0] pc;
        logic [tcfe_pkg::OPC_W-1:0]  opc;
        logic [tcfe_pkg::ADDR_W-1:0] opd;
        logic [tcfe_pkg::DATA_W-1:0] mbr;
        logic [tcfe_pkg::DATA_W-1:0] iobr;
        logic                        halted;
    } cpu_resp_t;

    typedef struct packed {
        logic [tcfe_pkg::ADDR_SPAN-1:0][tcfe_pkg::DATA_W-1:0]    mem;
        logic [tcfe_pkg::ADDR_SPAN-1:0]                          known;
        logic [tcfe_pkg::IO_DEPTH_DEF-1:0][tcfe_pkg::DATA_W-1:0] io;
        logic [tcfe_pkg::ADDR_W-1:0]                             pc;
        logic [tcfe_pkg::DATA_W-1:0]                             mbr;
        logic [tcfe_pkg::DATA_W-1:0]                             iobr;
        logic                                                    halted;
    } cpu_model_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [1:0]                    req_type  = '0;
    logic [tcfe_pkg::ADDR_W-1:0]   address   = '0;
    logic [tcfe_pkg::DATA_W-1:0]   data      = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [tcfe_pkg::DATA_W-1:0]   read_data;
    logic [tcfe_pkg::ADDR_W-1:0]   pc;
    logic [tcfe_pkg::OPC_W-1:0]    opcode;
    logic [tcfe_pkg::ADDR_W-1:0]   operand;
    logic [tcfe_pkg::DATA_W-1:0]   mbr;
    logic [tcfe_pkg::DATA_W-1:0]   iobr;
    logic                          halted;

    // cpu_state follows accepted requests, ahead_cpu follows queued ones
    cpu_model_t                    cpu_state = '0;
    cpu_model_t                    ahead_cpu = '0;
    cpu_req_t                      pending_reqs[$];
    cpu_resp_t                     awaited[$];
    logic [tcfe_pkg::ADDR_W-1:0]   loaded_addrs[$];

    int                  n_queued    = 0;
    int                  n_sent      = 0;
    int                  n_results   = 0;
    int                  n_errors    = 0;
    int                  cycles      = 0;
    int                  stall_left  = 0;
    bit                  stall_done  = 1'b0;
    bit                  in_taken    = 1'b0;

    toy_cpu_fetch_execute_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .address   (address),
        .data      (data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .pc        (pc),
        .opcode    (opcode),
        .operand   (operand),
        .mbr       (mbr),
        .iobr      (iobr),
        .halted    (halted)
    );

    always #1 clk = ~clk;

    function automatic cpu_resp_t execute_request(inout cpu_model_t s, input cpu_req_t r);
        cpu_resp_t                   o;
        logic [tcfe_pkg::ADDR_W-1:0] nxt;
        logic [tcfe_pkg::IR_W-1:0]   ir;
        o = '0;
        case (r.kind)
            tcfe_pkg::REQ_LOAD:
            begin
                s.mem[r.addr]   = r.value;
                s.known[r.addr] = 1'b1;
            end
            tcfe_pkg::REQ_READ_MEM: o.rd = s.mem[r.addr];
            tcfe_pkg::REQ_READ_IO:  o.rd = s.io[r.addr[IO_AW-1:0]];
            tcfe_pkg::REQ_STEP:
            begin
                if (!s.halted)
                begin
                    nxt   = s.pc + 11'd1;
                    ir    = {s.mem[s.pc], s.mem[nxt]};
                    s.pc  = s.pc + 11'd2;
                    o.opc = ir[15:11];
                    o.opd = ir[10:0];
                    case (o.opc)
                        tcfe_pkg::OP_WM:
                        begin
                            s.mem[o.opd]   = s.mbr;
                            s.known[o.opd] = 1'b1;
                        end
                        tcfe_pkg::OP_RM:  s.mbr    = s.mem[o.opd];
                        tcfe_pkg::OP_BR:  s.pc     = o.opd;
                        tcfe_pkg::OP_RIO: s.iobr   = s.io[o.opd[IO_AW-1:0]];
                        tcfe_pkg::OP_WIO: s.io[o.opd[IO_AW-1:0]] = s.iobr;
                        tcfe_pkg::OP_WB:  s.mbr    = ir[7:0];
                        tcfe_pkg::OP_WIB: s.iobr   = ir[7:0];
                        tcfe_pkg::OP_EOP: s.halted = 1'b1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        o.pc     = s.pc;
        o.mbr    = s.mbr;
        o.iobr   = s.iobr;
        o.halted = s.halted;
        return o;
    endfunction

    // A step is safe if it touches only written memory and does not halt early
    function automatic bit step_safe();
        logic [tcfe_pkg::ADDR_W-1:0] nxt;
        logic [tcfe_pkg::IR_W-1:0]   ir;
        if (ahead_cpu.halted)
            return 1'b1;
        nxt = ahead_cpu.pc + 11'd1;
        if (!ahead_cpu.known[ahead_cpu.pc] || !ahead_cpu.known[nxt])
            return 1'b0;
        ir = {ahead_cpu.mem[ahead_cpu.pc], ahead_cpu.mem[nxt]};
        if (ir[15:11] == tcfe_pkg::OP_EOP)
            return 1'b0;
        if (ir[15:11] == tcfe_pkg::OP_RM && !ahead_cpu.known[ir[10:0]])
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic push_req(input logic [1:0] kind, input logic [tcfe_pkg::ADDR_W-1:0] a,
                            input logic [tcfe_pkg::DATA_W-1:0] v);
        cpu_req_t r;
        r.kind  = kind;
        r.addr  = a;
        r.value = v;
        r.drain = 1'b0;
        void'(execute_request(ahead_cpu, r));
        pending_reqs.push_back(r);
        n_queued++;
        if (kind == tcfe_pkg::REQ_LOAD)
            loaded_addrs.push_back(a);
    endtask

    task automatic push_step();
        push_req(tcfe_pkg::REQ_STEP, 11'($urandom_range(2047)), 8'($urandom_range(255)));
    endtask

    // Place an instruction at the upcoming pc and execute it
    task automatic run_instr(input logic [tcfe_pkg::OPC_W-1:0] opc,
                             input logic [tcfe_pkg::ADDR_W-1:0] opd);
        logic [tcfe_pkg::ADDR_W-1:0] at;
        if (opc == tcfe_pkg::OP_RM && !ahead_cpu.known[opd])
            push_req(tcfe_pkg::REQ_LOAD, opd, 8'($urandom_range(255)));
        at = ahead_cpu.pc;
        push_req(tcfe_pkg::REQ_LOAD, at, {opc, opd[10:8]});
        push_req(tcfe_pkg::REQ_LOAD, at + 11'd1, opd[7:0]);
        push_step();
    endtask

    task automatic random_step();
        logic [tcfe_pkg::OPC_W-1:0] opc;
        int                         pick;
        if (step_safe() && $urandom_range(3) == 0)
        begin
            push_step();
        end
        else
        begin
            pick = $urandom_range(9);
            case (pick)
                0: opc = tcfe_pkg::OP_WM;
                1: opc = tcfe_pkg::OP_RM;
                2: opc = tcfe_pkg::OP_BR;
                3: opc = tcfe_pkg::OP_RIO;
                4: opc = tcfe_pkg::OP_WIO;
                5: opc = tcfe_pkg::OP_WB;
                6: opc = tcfe_pkg::OP_WIB;
                default:
                begin
                    opc = 5'($urandom_range(30));
                    if (opc >= tcfe_pkg::OP_WM && opc <= tcfe_pkg::OP_WIB)
                        opc = opc + 5'd8;
                end
            endcase
            run_instr(opc, 11'($urandom_range(2047)));
        end
    endtask

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                   n_results, name, got, want));
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Monitor: predict on each accepted item, check each delivered result
    always @(posedge clk)
    begin
        cpu_req_t  got;
        cpu_resp_t want;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            got.kind  = req_type;
            got.addr  = address;
            got.value = data;
            got.drain = 1'b0;
            awaited.push_back(execute_request(cpu_state, got));
        end
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (awaited.size() == 0)
            begin
                log_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
            end
            else
            begin
                want = awaited.pop_front();
                compare_field("read_data", 32'(read_data), 32'(want.rd));
                compare_field("pc",        32'(pc),        32'(want.pc));
                compare_field("opcode",    32'(opcode),    32'(want.opc));
                compare_field("operand",   32'(operand),   32'(want.opd));
                compare_field("mbr",       32'(mbr),       32'(want.mbr));
                compare_field("iobr",      32'(iobr),      32'(want.iobr));
                compare_field("halted",    32'(halted),    32'(want.halted));
            end
        end
    end

    // Driver: offer the next item once the current one is taken
    always @(negedge clk)
    begin
        cpu_req_t nx;
        logic     nv;
        if (rst_n && (!in_valid || in_taken))
        begin
            nv = 1'b0;
            if (pending_reqs.size() != 0 &&
                ((n_sent >= 500 && n_sent < 750) || $urandom_range(99) >= 6))
            begin
                if (pending_reqs[0].drain)
                begin
                    // hold until every outstanding result is back
                    if (awaited.size() == 0)
                        void'(pending_reqs.pop_front());
                end
                else
                begin
                    nx = pending_reqs.pop_front();
                    req_type <= nx.kind;
                    address  <= nx.addr;
                    data     <= nx.value;
                    nv = 1'b1;
                    n_sent++;
                end
            end
            in_valid <= nv;
        end
    end

    always @(negedge clk)
    begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0)
        begin
            stall_left--;
            rdy = 1'b0;
        end
        else if (!stall_done && n_results >= 300)
        begin
            // long hold-off: let the block fill up and stall its input
            stall_left = 150;
            stall_done = 1'b1;
            rdy = 1'b0;
        end
        else if (!(n_results >= 500 && n_results < 750) && $urandom_range(99) < 6)
        begin
            rdy = 1'b0;
        end
        out_ready <= rdy;
    end

    initial
    begin
        cpu_req_t hold;
        int       sel;
        int       k;
        bit       drained;
        drained = 1'b0;

        push_req(tcfe_pkg::REQ_READ_IO, 11'h7FF, 8'hFF);
        run_instr(tcfe_pkg::OP_WB, 11'h0A5);
        run_instr(tcfe_pkg::OP_WM, 11'h7FF);
        push_req(tcfe_pkg::REQ_READ_MEM, 11'h7FF, 8'h00);
        run_instr(tcfe_pkg::OP_WIB, 11'h0FF);
        run_instr(tcfe_pkg::OP_WIO, 11'h7FF);
        push_req(tcfe_pkg::REQ_READ_IO, 11'h01F, 8'h00);
        run_instr(tcfe_pkg::OP_RIO, 11'h000);
        run_instr(tcfe_pkg::OP_RM, 11'h7FF);
        run_instr(OP_NONE, 11'h000);
        // jump to the top of memory so the next fetch wraps between its bytes
        run_instr(tcfe_pkg::OP_BR, 11'h7FF);
        run_instr(OP_SPARE, 11'h7FF);

        while (n_queued < TOTAL_REQS)
        begin
            if (!drained && n_queued >= 700)
            begin
                hold = '0;
                hold.drain = 1'b1;
                pending_reqs.push_back(hold);
                drained = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 55)
            begin
                k = $urandom_range(1, 5);
                repeat (k) random_step();
            end
            else if (sel < 70)
                push_req(tcfe_pkg::REQ_LOAD, 11'($urandom_range(2047)),
                         8'($urandom_range(255)));
            else if (sel < 85)
                push_req(tcfe_pkg::REQ_READ_MEM,
                         loaded_addrs[$urandom_range(loaded_addrs.size() - 1)],
                         8'($urandom_range(255)));
            else
                push_req(tcfe_pkg::REQ_READ_IO, 11'($urandom_range(2047)),
                         8'($urandom_range(255)));
        end

        // end of program, then requests after the halt
        run_instr(tcfe_pkg::OP_EOP, 11'($urandom_range(2047)));
        push_step();
        push_step();
        push_req(tcfe_pkg::REQ_LOAD, 11'($urandom_range(2047)), 8'($urandom_range(255)));
        push_req(tcfe_pkg::REQ_READ_MEM,
                 loaded_addrs[$urandom_range(loaded_addrs.size() - 1)], 8'h00);
        push_req(tcfe_pkg::REQ_READ_IO, 11'($urandom_range(2047)), 8'h00);
        push_step();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid || awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (awaited.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", awaited.size()));
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### toy_cpu_fetch_execute_top.f
sv/tcfe_pkg.sv
sv/tcfe_main_mem.sv
sv/tcfe_io_mem.sv
sv/toy_cpu_fetch_execute_top.sv
bench/toy_cpu_fetch_execute_top_test.sv
